// File: rtl/assert_macros.svh
// assertion macros used by the rtl alu
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define FPA_ASSERT(name, cond) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// implication checked at every clock edge out of reset
`define FPA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/fpa_pkg.sv
// constants, opcodes and the pipeline stage type of the fixed-point alu
// no dependencies
package fpa_pkg;
    localparam int FRAC_BITS = 8;
    localparam int QW        = 32 + FRAC_BITS;
    localparam int NSTG      = QW + 3;

    localparam logic [3:0] OP_ADD     = 4'd0;
    localparam logic [3:0] OP_SUB     = 4'd1;
    localparam logic [3:0] OP_MUL     = 4'd2;
    localparam logic [3:0] OP_DIV     = 4'd3;
    localparam logic [3:0] OP_LT      = 4'd4;
    localparam logic [3:0] OP_LE      = 4'd5;
    localparam logic [3:0] OP_GT      = 4'd6;
    localparam logic [3:0] OP_GE      = 4'd7;
    localparam logic [3:0] OP_EQ      = 4'd8;
    localparam logic [3:0] OP_NE      = 4'd9;
    localparam logic [3:0] OP_MIN     = 4'd10;
    localparam logic [3:0] OP_MAX     = 4'd11;
    localparam logic [3:0] OP_INC     = 4'd12;
    localparam logic [3:0] OP_DEC     = 4'd13;
    localparam logic [3:0] OP_FROMINT = 4'd14;
    localparam logic [3:0] OP_TOINT   = 4'd15;

    localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN32 = 32'h8000_0000;

    typedef struct packed {
        logic          valid;
        logic [3:0]    kind;
        logic [31:0]   a;
        logic [31:0]   b;
        logic [31:0]   aa;
        logic [31:0]   ab;
    } t_in;

    typedef struct packed {
        logic          valid;
        logic [3:0]    kind;
        logic [31:0]   res;
        logic          cmp;
        logic          ovf;
        logic          dz;
        logic          neg;
        logic [63:0]   prod;
        logic [31:0]   den;
        logic [31:0]   rem;
        logic [QW-1:0] quo;
        logic [QW:0]   rnd;
    } t_stage;
endpackage

// File: rtl/fixed_point_q24_8_alu.sv
// Q24.8 fixed-point alu: add, sub, rounded mul and div, compares, min/max,
// inc/dec and integer conversion. Every item passes the input register and
// then the r_p pipeline stages, in which the divider resolves one quotient
// bit per stage. A new item can enter every cycle; the whole
// pipeline holds while a finished result is not taken.
// depends on fpa_pkg and assert_macros.svh
`include "assert_macros.svh"

module fixed_point_q24_8_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_kind,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result,
    output logic        o_compare_true,
    output logic        o_overflow,
    output logic        o_div_zero
);
    import fpa_pkg::*;

    localparam logic [63:0] MHALF = 64'(1) << (FRAC_BITS - 1);

    t_in    r_in;
    t_in    n_in;
    t_stage r_p [NSTG];
    t_stage n_p [NSTG];
    logic   en;

    function automatic logic [32:0] sat33(input logic [32:0] s);
        // bit 32 flags overflow, low bits hold the clamped value
        if (s[32] != s[31]) begin
            return {1'b1, (s[32] ? MIN32 : MAX32)};
        end
        return {1'b0, s[31:0]};
    endfunction

    assign en      = !r_p[NSTG-1].valid || i_ready;
    assign o_ready = en;

    always_comb begin
        n_in.valid = i_valid;
        n_in.kind  = i_kind;
        n_in.a     = i_operand_a;
        n_in.b     = i_operand_b;
        n_in.aa    = i_operand_a[31] ? (32'd0 - i_operand_a) : i_operand_a;
        n_in.ab    = i_operand_b[31] ? (32'd0 - i_operand_b) : i_operand_b;
    end

    always_comb begin
        logic signed [31:0]          sa;
        logic signed [31:0]          sb;
        logic [32:0]                 s;
        logic signed [31+FRAC_BITS:0] fi;
        logic [64:0]                 mr;
        logic [33:0]                 t;
        logic                        up;
        sa = r_in.a;
        sb = r_in.b;
        s  = '0;
        fi = '0;
        mr = '0;
        t  = '0;
        up = 1'b0;

        n_p[0]       = '0;
        n_p[0].valid = r_in.valid;
        n_p[0].kind  = r_in.kind;
        n_p[0].neg   = r_in.a[31] ^ r_in.b[31];
        n_p[0].prod  = 64'(r_in.aa) * 64'(r_in.ab);
        n_p[0].den   = r_in.ab;
        n_p[0].quo   = {r_in.aa, {FRAC_BITS{1'b0}}};
        n_p[0].dz    = (r_in.kind == OP_DIV) && (r_in.b == 32'd0);
        unique case (r_in.kind)
            OP_ADD: begin
                s = sat33({r_in.a[31], r_in.a} + {r_in.b[31], r_in.b});
                {n_p[0].ovf, n_p[0].res} = s;
            end
            OP_SUB: begin
                s = sat33({r_in.a[31], r_in.a} - {r_in.b[31], r_in.b});
                {n_p[0].ovf, n_p[0].res} = s;
            end
            OP_LT:  n_p[0].cmp = sa < sb;
            OP_LE:  n_p[0].cmp = sa <= sb;
            OP_GT:  n_p[0].cmp = sa > sb;
            OP_GE:  n_p[0].cmp = sa >= sb;
            OP_EQ:  n_p[0].cmp = sa == sb;
            OP_NE:  n_p[0].cmp = sa != sb;
            OP_MIN: n_p[0].res = (sa < sb) ? r_in.a : r_in.b;
            OP_MAX: n_p[0].res = (sa > sb) ? r_in.a : r_in.b;
            OP_INC: begin
                s = sat33({r_in.a[31], r_in.a} + 33'd1);
                {n_p[0].ovf, n_p[0].res} = s;
            end
            OP_DEC: begin
                s = sat33({r_in.a[31], r_in.a} - 33'd1);
                {n_p[0].ovf, n_p[0].res} = s;
            end
            OP_FROMINT: begin
                fi = {r_in.a, {FRAC_BITS{1'b0}}};
                if ((fi[31+FRAC_BITS:31] != '0) && (fi[31+FRAC_BITS:31] != '1)) begin
                    n_p[0].ovf = 1'b1;
                    n_p[0].res = r_in.a[31] ? MIN32 : MAX32;
                end else begin
                    n_p[0].res = fi[31:0];
                end
            end
            OP_TOINT: n_p[0].res = 32'(sa >>> FRAC_BITS);
            default: ;
        endcase

        for (int i = 1; i < NSTG; i++) begin
            n_p[i] = r_p[i-1];
            if (i <= QW) begin
                // one restoring divide step
                t = {1'b0, r_p[i-1].rem, r_p[i-1].quo[QW-1]};
                if (t[32:0] >= {1'b0, r_p[i-1].den}) begin
                    n_p[i].rem = 32'(t[32:0] - {1'b0, r_p[i-1].den});
                    n_p[i].quo = {r_p[i-1].quo[QW-2:0], 1'b1};
                end else begin
                    n_p[i].rem = t[31:0];
                    n_p[i].quo = {r_p[i-1].quo[QW-2:0], 1'b0};
                end
            end
            if (i == 1) begin
                mr = {1'b0, r_p[i-1].prod} + {1'b0, MHALF};
                n_p[i].prod = 64'(mr >> FRAC_BITS);
            end
            if ((i == 2) && (r_p[i-1].kind == OP_MUL)) begin
                if (r_p[i-1].neg) begin
                    if (r_p[i-1].prod > 64'(MIN32)) begin
                        n_p[i].ovf = 1'b1;
                        n_p[i].res = MIN32;
                    end else begin
                        n_p[i].res = 32'd0 - r_p[i-1].prod[31:0];
                    end
                end else if (r_p[i-1].prod > 64'(MAX32)) begin
                    n_p[i].ovf = 1'b1;
                    n_p[i].res = MAX32;
                end else begin
                    n_p[i].res = r_p[i-1].prod[31:0];
                end
            end
            if (i == QW + 1) begin
                up = {r_p[i-1].rem, 1'b0} >= {1'b0, r_p[i-1].den};
                n_p[i].rnd = {1'b0, r_p[i-1].quo} + (QW+1)'(up);
            end
            if ((i == QW + 2) && (r_p[i-1].kind == OP_DIV)) begin
                if (r_p[i-1].dz) begin
                    n_p[i].res = 32'd0;
                end else if (r_p[i-1].neg) begin
                    if (r_p[i-1].rnd > (QW+1)'(MIN32)) begin
                        n_p[i].ovf = 1'b1;
                        n_p[i].res = MIN32;
                    end else begin
                        n_p[i].res = 32'd0 - r_p[i-1].rnd[31:0];
                    end
                end else if (r_p[i-1].rnd > (QW+1)'(MAX32)) begin
                    n_p[i].ovf = 1'b1;
                    n_p[i].res = MAX32;
                end else begin
                    n_p[i].res = r_p[i-1].rnd[31:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
            for (int i = 0; i < NSTG; i++) begin
                r_p[i].valid <= 1'b0;
            end
        end else if (en) begin
            r_in <= n_in;
            for (int i = 0; i < NSTG; i++) begin
                r_p[i] <= n_p[i];
            end
        end
    end

    assign o_valid        = r_p[NSTG-1].valid;
    assign o_result       = r_p[NSTG-1].res;
    assign o_compare_true = r_p[NSTG-1].cmp;
    assign o_overflow     = r_p[NSTG-1].ovf;
    assign o_div_zero     = r_p[NSTG-1].dz;

    `FPA_ASSERT_IMP(a_cmp_clean, o_valid && o_compare_true, (o_result == '0) && !o_overflow)
    `FPA_ASSERT_IMP(a_dz_clean, o_valid && o_div_zero, (o_result == '0) && !o_overflow)
    `FPA_ASSERT_IMP(a_ovf_bound, o_valid && o_overflow, (o_result == MAX32) || (o_result == MIN32))
endmodule

// File: tb/sv/fixed_point_q24_8_alu_tb.sv
// self-checking testbench for the q24.8 fixed-point alu: a directed table, then random items
// under four idle/stall phases, each result checked against its table value or an integer predictor
// depends on fpa_pkg and the rtl top fixed_point_q24_8_alu
`timescale 1ns / 100ps

module fixed_point_q24_8_alu_tb;
    import fpa_pkg::*;

    localparam int N_DIRECTED = 22;
    localparam int N_RANDOM   = 1600;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [31:0] result;
        logic        cmp;
        logic        ovf;
        logic        dz;
    } t_alu_res;

    typedef struct {
        logic [3:0]  kind;
        logic [31:0] a;
        logic [31:0] b;
        bit          fixed;
        t_alu_res    res;
    } t_alu_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [3:0]  i_kind;
    logic [31:0] i_operand_a;
    logic [31:0] i_operand_b;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_result;
    logic        o_compare_true;
    logic        o_overflow;
    logic        o_div_zero;

    t_alu_item stim_q[$];
    t_alu_res  pending_q[$];
    int        sent_cnt;
    int        idle_pct;
    int        stall_pct;
    int        err_cnt;
    int        cycle_cnt;
    bit        all_sent;

    fixed_point_q24_8_alu u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result       (o_result),
        .o_compare_true (o_compare_true),
        .o_overflow     (o_overflow),
        .o_div_zero     (o_div_zero)
    );

    function automatic longint sat32(longint v, ref logic ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // half away from zero
    function automatic longint round_quot(longint num, longint den);
        longint unsigned n;
        longint unsigned d;
        longint unsigned q;
        bit              neg;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = (2 * n + d) / (2 * d);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_alu_res predict_alu(logic [3:0] kind, logic [31:0] a_bits,
                                             logic [31:0] b_bits);
        longint   a;
        longint   b;
        longint   r;
        longint   one;
        logic     ovf;
        t_alu_res res;
        a = longint'(signed'(a_bits));
        b = longint'(signed'(b_bits));
        one = longint'(1) << FRAC_BITS;
        r = 0;
        ovf = 1'b0;
        res.cmp = 1'b0;
        res.dz = 1'b0;
        case (kind)
            OP_ADD: r = sat32(a + b, ovf);
            OP_SUB: r = sat32(a - b, ovf);
            OP_MUL: r = sat32(round_quot(a * b, one), ovf);
            OP_DIV: begin
                if (b == 0) res.dz = 1'b1;
                else r = sat32(round_quot(a * one, b), ovf);
            end
            OP_LT: res.cmp = a < b;
            OP_LE: res.cmp = a <= b;
            OP_GT: res.cmp = a > b;
            OP_GE: res.cmp = a >= b;
            OP_EQ: res.cmp = a == b;
            OP_NE: res.cmp = a != b;
            OP_MIN: r = (a < b) ? a : b;
            OP_MAX: r = (a > b) ? a : b;
            OP_INC: r = sat32(a + 1, ovf);
            OP_DEC: r = sat32(a - 1, ovf);
            OP_FROMINT: r = sat32(a * one, ovf);
            default: r = a >>> FRAC_BITS;
        endcase
        res.result = r[31:0];
        res.ovf = ovf;
        return res;
    endfunction

    function automatic void add_row(logic [3:0] kind, logic [31:0] a, logic [31:0] b,
                                    bit fixed, logic [31:0] r, logic cmp, logic ovf,
                                    logic dz);
        t_alu_item it;
        it.kind = kind;
        it.a = a;
        it.b = b;
        it.fixed = fixed;
        it.res.result = r;
        it.res.cmp = cmp;
        it.res.ovf = ovf;
        it.res.dz = dz;
        stim_q.push_back(it);
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0, 1, 2: return $urandom;
            3: return $urandom_range(0, 4095) - 2048;
            4: return ($urandom_range(0, 1)) ? MAX32 : MIN32;
            5: return $urandom_range(0, 2) - 1;
            6: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            default: return ($urandom_range(0, 255) - 128) << FRAC_BITS;
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // stimulus: table first, then random items
    initial begin
        t_alu_item it;
        cycle_cnt = 0;
        err_cnt = 0;
        sent_cnt = 0;
        all_sent = 0;
        idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_kind = OP_ADD;
        i_operand_a = '0;
        i_operand_b = '0;

        add_row(OP_ADD, MAX32, 32'd1, 1, MAX32, 0, 1, 0);
        add_row(OP_ADD, MIN32, MIN32, 1, MIN32, 0, 1, 0);
        add_row(OP_SUB, MIN32, 32'd1, 1, MIN32, 0, 1, 0);
        add_row(OP_SUB, MAX32, 32'hFFFF_FFFF, 1, MAX32, 0, 1, 0);
        add_row(OP_MUL, MAX32, MAX32, 1, MAX32, 0, 1, 0);
        add_row(OP_MUL, 32'h0000_0180, 32'h0000_0080, 0, 0, 0, 0, 0);
        add_row(OP_MUL, 32'hFFFF_FE80, 32'h0000_0080, 0, 0, 0, 0, 0);
        add_row(OP_DIV, 32'h0000_0100, 32'd0, 1, 32'd0, 0, 0, 1);
        add_row(OP_DIV, MIN32, 32'd1, 1, MIN32, 0, 1, 0);
        add_row(OP_DIV, 32'h0000_0100, 32'h0000_0300, 0, 0, 0, 0, 0);
        add_row(OP_LT, MIN32, MAX32, 1, 32'd0, 1, 0, 0);
        add_row(OP_LE, MAX32, MAX32, 1, 32'd0, 1, 0, 0);
        add_row(OP_GT, MIN32, MAX32, 1, 32'd0, 0, 0, 0);
        add_row(OP_GE, 32'd5, 32'd5, 1, 32'd0, 1, 0, 0);
        add_row(OP_EQ, MIN32, MIN32, 1, 32'd0, 1, 0, 0);
        add_row(OP_NE, MIN32, MIN32, 1, 32'd0, 0, 0, 0);
        add_row(OP_MIN, 32'd7, 32'd7, 1, 32'd7, 0, 0, 0);
        add_row(OP_MAX, MIN32, MAX32, 1, MAX32, 0, 0, 0);
        add_row(OP_INC, MAX32, 32'd0, 1, MAX32, 0, 1, 0);
        add_row(OP_DEC, MIN32, 32'd0, 1, MIN32, 0, 1, 0);
        add_row(OP_FROMINT, MAX32, 32'd0, 1, MAX32, 0, 1, 0);
        add_row(OP_TOINT, MIN32, 32'd0, 1, 32'hFF80_0000, 0, 0, 0);
        for (int i = 0; i < N_RANDOM; i++) begin
            it.kind = 4'($urandom_range(0, 15));
            it.a = pick_operand();
            it.b = pick_operand();
            it.fixed = 0;
            stim_q.push_back(it);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        forever begin
            @(posedge i_clk);
            if (i_valid && o_ready) begin
                it = stim_q[sent_cnt];
                if (it.fixed) begin
                    pending_q.push_back(it.res);
                end else begin
                    pending_q.push_back(predict_alu(i_kind, i_operand_a, i_operand_b));
                end
                sent_cnt++;
            end
            if (sent_cnt < N_DIRECTED) begin
                idle_pct = 0;
                stall_pct = 0;
            end else begin
                case ((sent_cnt - N_DIRECTED) * 4 / N_RANDOM)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 85; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 85; end
                    default: begin idle_pct = 27; stall_pct = 27; end
                endcase
            end
            if (sent_cnt >= stim_q.size()) begin
                i_valid <= 1'b0;
                break;
            end
            if (!i_valid || o_ready) begin
                if ($urandom_range(0, 99) >= idle_pct) begin
                    it = stim_q[sent_cnt];
                    i_valid <= 1'b1;
                    i_kind <= it.kind;
                    i_operand_a <= it.a;
                    i_operand_b <= it.b;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
        all_sent = 1;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // result side: check each transfer, then pick the next ready
    always @(posedge i_clk) begin
        t_alu_res exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_q.size() == 0) begin
                $error("result transfer with nothing pending");
                err_cnt++;
            end else begin
                exp_res = pending_q.pop_front();
                if (o_result !== exp_res.result) begin
                    $error("result: expected %h, actual %h", exp_res.result, o_result);
                    err_cnt++;
                end
                if (o_compare_true !== exp_res.cmp) begin
                    $error("compare_true: expected %b, actual %b", exp_res.cmp,
                           o_compare_true);
                    err_cnt++;
                end
                if (o_overflow !== exp_res.ovf) begin
                    $error("overflow: expected %b, actual %b", exp_res.ovf, o_overflow);
                    err_cnt++;
                end
                if (o_div_zero !== exp_res.dz) begin
                    $error("div_zero: expected %b, actual %b", exp_res.dz, o_div_zero);
                    err_cnt++;
                end
            end
        end
        if (!i_rst_n) i_ready <= 1'b0;
        else if (all_sent) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/fpa_pkg.sv
rtl/fixed_point_q24_8_alu.sv
tb/sv/fixed_point_q24_8_alu_tb.sv
